[hw/rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants for the triangle face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int VERTEX_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int VERT_W       = 48;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_FACE  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [9:0]        vertex_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic [9:0]        corner_a;
        logic [9:0]        corner_b;
        logic [9:0]        corner_c;
        logic              last_face;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic              degenerate;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vertex_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_CAP_C,
        ST_MUL,
        ST_CHK,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_LATCH,
        OP_RD_A,
        OP_RD_B,
        OP_RD_C,
        OP_CAP_C,
        OP_MUL,
        OP_CHK,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_OUT
    } dp_op_t;

    localparam logic [3:0] MUL_LAST  = 4'd15;
    localparam logic [5:0] SQRT_LAST = 6'd34;
    localparam logic [3:0] DIV_LAST  = 4'd15;
    localparam logic [1:0] COMP_X    = 2'd0;
    localparam logic [1:0] COMP_Y    = 2'd1;
    localparam logic [1:0] COMP_Z    = 2'd2;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] step;
        logic [1:0] comp;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic s_zero;
    } dp_status_t;

endpackage

[hw/rtl/triangle_face_normal.sv]
// A vertex write is taken in the idle state. A face runs through the store reads,
// 16 multiply steps, 35 square root steps and three 16-step divisions on one
// shared divider; a degenerate face skips the square root and the divisions.
// Throughput: one face at a time; the next transfer is taken once the result
// sits in the output register. Reset (aresetn low, synchronous) clears control
// and output valid; the vertex store holds no defined contents until written.
// ----------------------------------------------------------------------------
// triangle_face_normal
// Top level: unit face normal of stored triangle vertices in Q1.14.
// ----------------------------------------------------------------------------
module triangle_face_normal (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tfn_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output tfn_pkg::out_item_t m_payload
);
    import tfn_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tfn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_payload.action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    tfn_datapath u_datapath (
        .aclk      (aclk),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_payload (m_payload)
    );

endmodule

[hw/rtl/tfn_ram.sv]
// ----------------------------------------------------------------------------
// tfn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/tfn_ctrl.sv]
// ----------------------------------------------------------------------------
// tfn_ctrl
// Sequencer: vertex reads, multiply schedule, square root and divisions.
// ----------------------------------------------------------------------------
module tfn_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_action,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tfn_pkg::dp_cmd_t    cmd,
    input  tfn_pkg::dp_status_t status
);
    import tfn_pkg::*;

    ctl_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            comp_reg    <= COMP_X;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            comp_reg    <= comp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        comp_next    = comp_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        s_ready      = 1'b0;
        cmd.op       = OP_NONE;
        cmd.step     = cnt_reg[3:0];
        cmd.comp     = comp_reg;
        cmd.last     = (cnt_reg[3:0] == DIV_LAST);
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action == ACT_FACE) begin
                        cmd.op     = OP_LATCH;
                        state_next = ST_RD_A;
                    end else begin
                        cmd.op = OP_WRITE;
                    end
                end
            end
            ST_RD_A: begin
                cmd.op     = OP_RD_A;
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.op     = OP_RD_B;
                state_next = ST_RD_C;
            end
            ST_RD_C: begin
                cmd.op     = OP_RD_C;
                state_next = ST_CAP_C;
            end
            ST_CAP_C: begin
                cmd.op     = OP_CAP_C;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.op   = OP_MUL;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[3:0] == MUL_LAST) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                cmd.op    = OP_CHK;
                cnt_next  = '0;
                comp_next = COMP_X;
                state_next = status.s_zero ? ST_OUT : ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.op   = (cnt_reg[3:0] == 4'd0) ? OP_DIV_INIT : OP_DIV_STEP;
                cnt_next = {2'b00, cnt_reg[3:0] + 4'd1};
                if (cnt_reg[3:0] == DIV_LAST) begin
                    cnt_next = '0;
                    if (comp_reg == COMP_Z) begin
                        state_next = ST_OUT;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

[hw/rtl/tfn_datapath.sv]
// ----------------------------------------------------------------------------
// tfn_datapath
// Vertex store, shared multiplier, digit-serial square root and divider.
// ----------------------------------------------------------------------------
module tfn_datapath (
    input  logic                aclk,
    input  tfn_pkg::in_item_t   s_payload,
    input  tfn_pkg::dp_cmd_t    cmd,
    output tfn_pkg::dp_status_t status,
    output tfn_pkg::out_item_t  m_payload
);
    import tfn_pkg::*;

    logic [9:0]  corner_a_reg, corner_b_reg, corner_c_reg;
    logic [2:0]  ok_reg;
    logic        last_reg;
    vertex_t     va_reg, vb_reg, vc_reg, rd_vert;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [VERT_W-1:0] ram_rdata;

    logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [17:0] op_a, op_b;
    logic signed [35:0] prod_reg;
    logic signed [34:0] cx_reg, cy_reg, cz_reg;
    logic [33:0]        mx, my, mz, msel;
    logic [69:0]        s_reg;
    logic [69:0]        p_ext;

    logic [36:0] rem_reg;
    logic [34:0] root_reg;
    logic [38:0] rem2;
    logic [36:0] trial;

    logic [35:0] drem_reg;
    logic [14:0] dlow_reg;
    logic [14:0] q_reg, q_next;
    logic [36:0] dt;
    logic [35:0] dvsr;
    logic        ge;
    logic        neg_sel;
    logic        deg_reg;

    logic signed [15:0] normal_reg [3];
    out_item_t          out_reg;

    function automatic logic [33:0] mag34(input logic signed [34:0] v);
        logic [34:0] a;
        a = v[34] ? 35'(-v) : 35'(v);
        return a[33:0];
    endfunction

    // vertex store
    assign ram_we    = (cmd.op == OP_WRITE) && (32'(s_payload.vertex_index) < VERTEX_DEPTH);
    assign ram_waddr = ADDR_W'(s_payload.vertex_index);

    always_comb begin
        case (cmd.op)
            OP_RD_B: ram_raddr = ADDR_W'(corner_b_reg);
            OP_RD_C: ram_raddr = ADDR_W'(corner_c_reg);
            default: ram_raddr = ADDR_W'(corner_a_reg);
        endcase
    end

    tfn_ram #(.WIDTH(VERT_W), .DEPTH(VERTEX_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({s_payload.coord_x, s_payload.coord_y, s_payload.coord_z}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_vert = vertex_t'(ram_rdata);

    // edges and multiplier operands
    assign e1x = 17'(vb_reg.x) - 17'(va_reg.x);
    assign e1y = 17'(vb_reg.y) - 17'(va_reg.y);
    assign e1z = 17'(vb_reg.z) - 17'(va_reg.z);
    assign e2x = 17'(vc_reg.x) - 17'(va_reg.x);
    assign e2y = 17'(vc_reg.y) - 17'(va_reg.y);
    assign e2z = 17'(vc_reg.z) - 17'(va_reg.z);

    assign mx = mag34(cx_reg);
    assign my = mag34(cy_reg);
    assign mz = mag34(cz_reg);

    always_comb begin
        case (cmd.step)
            4'd0:  begin op_a = 18'(e1y); op_b = 18'(e2z); end
            4'd1:  begin op_a = 18'(e1z); op_b = 18'(e2y); end
            4'd2:  begin op_a = 18'(e1z); op_b = 18'(e2x); end
            4'd3:  begin op_a = 18'(e1x); op_b = 18'(e2z); end
            4'd4:  begin op_a = 18'(e1x); op_b = 18'(e2y); end
            4'd5:  begin op_a = 18'(e1y); op_b = 18'(e2x); end
            4'd6:  begin op_a = {1'b0, mx[16:0]};  op_b = {1'b0, mx[16:0]}; end
            4'd7:  begin op_a = {1'b0, mx[33:17]}; op_b = {1'b0, mx[16:0]}; end
            4'd8:  begin op_a = {1'b0, mx[33:17]}; op_b = {1'b0, mx[33:17]}; end
            4'd9:  begin op_a = {1'b0, my[16:0]};  op_b = {1'b0, my[16:0]}; end
            4'd10: begin op_a = {1'b0, my[33:17]}; op_b = {1'b0, my[16:0]}; end
            4'd11: begin op_a = {1'b0, my[33:17]}; op_b = {1'b0, my[33:17]}; end
            4'd12: begin op_a = {1'b0, mz[16:0]};  op_b = {1'b0, mz[16:0]}; end
            4'd13: begin op_a = {1'b0, mz[33:17]}; op_b = {1'b0, mz[16:0]}; end
            4'd14: begin op_a = {1'b0, mz[33:17]}; op_b = {1'b0, mz[33:17]}; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign p_ext = {36'b0, prod_reg[33:0]};

    // square root digit
    assign rem2  = {rem_reg, s_reg[69:68]};
    assign trial = {root_reg, 2'b01};

    // divider step: the cross term doubles, so the divisor is 2r
    assign dvsr   = {root_reg, 1'b0};
    assign dt     = {drem_reg, dlow_reg[14]};
    assign ge     = (dt >= {1'b0, dvsr});
    assign q_next = {q_reg[13:0], ge};

    always_comb begin
        case (cmd.comp)
            COMP_X:  begin msel = mx; neg_sel = cx_reg[34]; end
            COMP_Y:  begin msel = my; neg_sel = cy_reg[34]; end
            default: begin msel = mz; neg_sel = cz_reg[34]; end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LATCH: begin
                corner_a_reg <= s_payload.corner_a;
                corner_b_reg <= s_payload.corner_b;
                corner_c_reg <= s_payload.corner_c;
                last_reg     <= s_payload.last_face;
                ok_reg <= {32'(s_payload.corner_c) < VERTEX_DEPTH,
                           32'(s_payload.corner_b) < VERTEX_DEPTH,
                           32'(s_payload.corner_a) < VERTEX_DEPTH};
            end
            OP_RD_B: begin
                va_reg <= ok_reg[0] ? rd_vert : '0;
            end
            OP_RD_C: begin
                vb_reg <= ok_reg[1] ? rd_vert : '0;
            end
            OP_CAP_C: begin
                vc_reg <= ok_reg[2] ? rd_vert : '0;
            end
            OP_MUL: begin
                prod_reg <= op_a * op_b;
                // fold in the product issued one step earlier
                case (cmd.step)
                    4'd1:  cx_reg <= 35'(prod_reg);
                    4'd2:  cx_reg <= cx_reg - 35'(prod_reg);
                    4'd3:  cy_reg <= 35'(prod_reg);
                    4'd4:  cy_reg <= cy_reg - 35'(prod_reg);
                    4'd5:  cz_reg <= 35'(prod_reg);
                    4'd6:  cz_reg <= cz_reg - 35'(prod_reg);
                    4'd7:  s_reg  <= p_ext;
                    4'd8, 4'd11, 4'd14: s_reg <= s_reg + (p_ext << 18);
                    4'd9, 4'd12, 4'd15: s_reg <= s_reg + (p_ext << 34);
                    4'd10, 4'd13: s_reg <= s_reg + p_ext;
                    default: ;
                endcase
            end
            OP_CHK: begin
                deg_reg  <= (s_reg == '0);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQRT: begin
                s_reg <= s_reg << 2;
                if (rem2 >= {2'b00, trial}) begin
                    rem_reg  <= 37'(rem2 - {2'b00, trial});
                    root_reg <= {root_reg[33:0], 1'b1};
                end else begin
                    rem_reg  <= rem2[36:0];
                    root_reg <= {root_reg[33:0], 1'b0};
                end
            end
            OP_DIV_INIT: begin
                // numerator is |c| * 2^15 + r; start with its upper part
                drem_reg <= 36'(msel) + 36'(root_reg[34:15]);
                dlow_reg <= root_reg[14:0];
                q_reg    <= '0;
            end
            OP_DIV_STEP: begin
                drem_reg <= ge ? 36'(dt - {1'b0, dvsr}) : dt[35:0];
                dlow_reg <= {dlow_reg[13:0], 1'b0};
                q_reg    <= q_next;
                if (cmd.last) begin
                    normal_reg[cmd.comp] <= neg_sel ? -16'(q_next) : 16'(q_next);
                end
            end
            OP_OUT: begin
                out_reg.normal_x   <= deg_reg ? '0 : normal_reg[0];
                out_reg.normal_y   <= deg_reg ? '0 : normal_reg[1];
                out_reg.normal_z   <= deg_reg ? '0 : normal_reg[2];
                out_reg.degenerate <= deg_reg;
                out_reg.last       <= last_reg;
            end
            default: ;
        endcase
    end

    assign status.s_zero = (s_reg == '0);
    assign m_payload     = out_reg;

endmodule
